[rtl/luhn_pkg.sv]
// Shared types, constants and helper functions of the Luhn card number classifier.
package luhn_pkg;

  localparam int CARD_W    = 63;
  localparam int NUM_CELLS = 19;
  localparam int DIGIT_W   = 4;
  localparam int TOTAL_W   = 5;
  localparam int KIND_W    = 2;
  localparam int POS_W     = 5;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AMEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MC   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_VISA = 2'd3;

  typedef struct packed {
    logic clr;
    logic dabble;
    logic scan;
  } cell_ctrl_t;

  typedef struct packed {
    logic             clr;
    logic             en;
    logic [POS_W-1:0] pos;
  } scan_ctrl_t;

  typedef struct packed {
    logic               ok;
    logic [TOTAL_W-1:0] total;
    logic [DIGIT_W-1:0] lead1;
    logic [DIGIT_W-1:0] lead_lo;
  } acc_stat_t;

  // doubled digit folded to a single digit
  function automatic logic [DIGIT_W-1:0] luhn_dbl(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] t;
    t = {d, 1'b0};
    if (t > 5'd9) begin
      return DIGIT_W'(t - 5'd9);
    end
    return t[DIGIT_W-1:0];
  endfunction

endpackage

[rtl/luhn_cell.sv]
// One BCD digit cell: double-dabble shift during conversion, digit shift during the scan.
module luhn_cell (
  input  logic                         clk,
  input  luhn_pkg::cell_ctrl_t         ctrl,
  input  logic                         bit_in,
  input  logic [luhn_pkg::DIGIT_W-1:0] digit_in,
  output logic                         bit_out,
  output logic [luhn_pkg::DIGIT_W-1:0] digit_out
);

  logic [luhn_pkg::DIGIT_W-1:0] digit_r;
  logic [luhn_pkg::DIGIT_W-1:0] digit_nxt;
  logic [luhn_pkg::DIGIT_W-1:0] adj;

  assign adj       = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out   = adj[luhn_pkg::DIGIT_W-1];
  assign digit_out = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[luhn_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctrl.scan) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

[rtl/luhn_acc.sv]
// Digit scan at the end of the cell row: Luhn sum mod ten, digit count and leading digits.
module luhn_acc (
  input  logic                         clk,
  input  luhn_pkg::scan_ctrl_t         ctrl,
  input  logic [luhn_pkg::DIGIT_W-1:0] digit,
  output luhn_pkg::acc_stat_t          stat
);

  logic [luhn_pkg::DIGIT_W-1:0] sum_r, sum_nxt;
  logic [luhn_pkg::DIGIT_W-1:0] prev_r, prev_nxt;
  logic [luhn_pkg::DIGIT_W-1:0] lead1_r, lead1_nxt;
  logic [luhn_pkg::DIGIT_W-1:0] lead_lo_r, lead_lo_nxt;
  logic [luhn_pkg::POS_W-1:0]   last_nz_r, last_nz_nxt;
  logic [luhn_pkg::DIGIT_W-1:0] contrib;
  logic [luhn_pkg::DIGIT_W:0]   s;

  assign contrib = ctrl.pos[0] ? luhn_pkg::luhn_dbl(digit) : digit;
  assign s       = {1'b0, sum_r} + {1'b0, contrib};

  always_comb begin
    sum_nxt     = sum_r;
    prev_nxt    = prev_r;
    lead1_nxt   = lead1_r;
    lead_lo_nxt = lead_lo_r;
    last_nz_nxt = last_nz_r;
    if (ctrl.clr) begin
      sum_nxt     = '0;
      prev_nxt    = '0;
      lead1_nxt   = '0;
      lead_lo_nxt = '0;
      last_nz_nxt = '0;
    end else if (ctrl.en) begin
      sum_nxt  = (s >= 5'd10) ? luhn_pkg::DIGIT_W'(s - 5'd10) : s[luhn_pkg::DIGIT_W-1:0];
      prev_nxt = digit;
      if (digit != '0) begin
        last_nz_nxt = ctrl.pos;
        lead1_nxt   = digit;
        lead_lo_nxt = prev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    prev_r    <= prev_nxt;
    lead1_r   <= lead1_nxt;
    lead_lo_r <= lead_lo_nxt;
    last_nz_r <= last_nz_nxt;
  end

  assign stat.ok      = (sum_r == '0);
  assign stat.total   = luhn_pkg::TOTAL_W'(last_nz_r) + luhn_pkg::TOTAL_W'(1);
  assign stat.lead1   = lead1_r;
  assign stat.lead_lo = lead_lo_r;

endmodule

[rtl/luhn_card_number_classifier.sv]
// Top level of the Luhn card number classifier: sequencer, cell row, scan and output register.
// A request passes through the bit-serial double dabble into the 19-cell BCD row, the digit-serial
// scan out of the row and a finish state that loads the output register; the finish state waits
// while the output register holds an untaken result. A new request is taken only in idle.
// A new request is taken while a finished result waits in the output register.
// Reset (rst_n, synchronous, active low) clears the sequencer and the output valid flag.
module luhn_card_number_classifier #(
  parameter int MAX_DIGITS = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [62:0] card_value, [63] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] card_kind, [2] checksum_ok, [7:3] digit_total
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(luhn_pkg::CARD_W - 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(luhn_pkg::NUM_CELLS - 1);

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [luhn_pkg::CARD_W-1:0] sh_r, sh_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_data_r, out_data_nxt;

  logic                        accept;
  logic                        out_free;
  luhn_pkg::cell_ctrl_t        cctrl;
  luhn_pkg::scan_ctrl_t        sctrl;
  luhn_pkg::acc_stat_t         stat;

  logic [luhn_pkg::DIGIT_W-1:0] digit_w [luhn_pkg::NUM_CELLS];
  logic                         carry_w [luhn_pkg::NUM_CELLS];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cctrl.clr    = accept;
  assign cctrl.dabble = (state_r == ST_CONV);
  assign cctrl.scan   = (state_r == ST_SCAN);

  assign sctrl.clr = accept;
  assign sctrl.en  = (state_r == ST_SCAN);
  assign sctrl.pos = cnt_r[luhn_pkg::POS_W-1:0];

  for (genvar i = 0; i < luhn_pkg::NUM_CELLS; i++) begin : g_cell
    logic                         bin;
    logic [luhn_pkg::DIGIT_W-1:0] din;
    if (i == 0) begin : g_first
      assign bin = sh_r[luhn_pkg::CARD_W-1];
    end else begin : g_mid
      assign bin = carry_w[i-1];
    end
    if (i == luhn_pkg::NUM_CELLS - 1) begin : g_top
      assign din = '0;
    end else begin : g_low
      assign din = digit_w[i+1];
    end
    luhn_cell u_cell (
      .clk       (clk),
      .ctrl      (cctrl),
      .bit_in    (bin),
      .digit_in  (din),
      .bit_out   (carry_w[i]),
      .digit_out (digit_w[i])
    );
  end

  luhn_acc u_acc (
    .clk   (clk),
    .ctrl  (sctrl),
    .digit (digit_w[0]),
    .stat  (stat)
  );

  logic                          over;
  logic                          ok_f;
  logic [luhn_pkg::KIND_W-1:0]   kind;
  logic [luhn_pkg::TOTAL_W-1:0]  total_f;

  always_comb begin
    over    = (stat.total > luhn_pkg::TOTAL_W'(MAX_DIGITS));
    ok_f    = stat.ok && !over;
    total_f = over ? luhn_pkg::TOTAL_W'(MAX_DIGITS) : stat.total;
    kind    = luhn_pkg::KIND_NONE;
    if (ok_f) begin
      if (stat.total == 5'd15 && stat.lead1 == 4'd3 &&
          (stat.lead_lo == 4'd4 || stat.lead_lo == 4'd7)) begin
        kind = luhn_pkg::KIND_AMEX;
      end else if (stat.total == 5'd16 && stat.lead1 == 4'd5 &&
                   stat.lead_lo >= 4'd1 && stat.lead_lo <= 4'd5) begin
        kind = luhn_pkg::KIND_MC;
      end else if ((stat.total == 5'd13 || stat.total == 5'd16) && stat.lead1 == 4'd4) begin
        kind = luhn_pkg::KIND_VISA;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sh_nxt        = sh_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sh_nxt    = in_tdata[luhn_pkg::CARD_W-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        sh_nxt = {sh_r[luhn_pkg::CARD_W-2:0], 1'b0};
        if (cnt_r == CONV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {total_f, ok_f, kind};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[tb/sv/luhn_card_number_checker.sv]
// Checker for the Luhn card number classifier: watches both channels, predicts and scores results.
module luhn_card_number_checker #(
  parameter int MAX_DIGITS = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [62:0] card_value, [63] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [1:0] card_kind, [2] checksum_ok, [7:3] digit_total
  output int          mismatch_cnt,
  output int          pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIGIT_SLOTS = 20;

  typedef struct packed {
    logic [luhn_pkg::CARD_W-1:0]  card;
    logic [luhn_pkg::KIND_W-1:0]  kind;
    logic                         ok;
    logic [luhn_pkg::TOTAL_W-1:0] total;
  } card_verdict_t;

  card_verdict_t verdict_q[$];
  int            report_lines;

  initial begin
    mismatch_cnt = 0;
    pending_cnt  = 0;
    report_lines = 0;
  end

  function automatic card_verdict_t classify_card(input logic [luhn_pkg::CARD_W-1:0] card);
    logic [63:0]   rest;
    int unsigned   dig[DIGIT_SLOTS];
    int unsigned   cnt;
    int unsigned   sum;
    int unsigned   x;
    int unsigned   p;
    int unsigned   lead1;
    int unsigned   lead2;
    card_verdict_t v;
    v.card  = card;
    v.kind  = luhn_pkg::KIND_NONE;
    v.ok    = 1'b0;
    v.total = luhn_pkg::TOTAL_W'(MAX_DIGITS);
    rest    = {1'b0, card};
    dig[0]  = 32'(rest % 64'd10);
    rest    = rest / 64'd10;
    cnt     = 1;
    while (rest != 64'd0 && cnt < DIGIT_SLOTS) begin
      dig[cnt] = 32'(rest % 64'd10);
      rest     = rest / 64'd10;
      cnt++;
    end
    // saturate on more digits than the row holds
    if (cnt > MAX_DIGITS || cnt > DIGIT_SLOTS - 1) begin
      return v;
    end
    sum = 0;
    for (p = 0; p < cnt; p++) begin
      x = dig[p];
      if ((p % 2) == 1) begin
        x = 2 * x;
        if (x > 9) begin
          x = x - 9;
        end
      end
      sum += x;
    end
    v.ok    = ((sum % 10) == 0);
    v.total = luhn_pkg::TOTAL_W'(cnt);
    lead1   = dig[cnt-1];
    lead2   = (cnt >= 2) ? lead1 * 10 + dig[cnt-2] : lead1;
    if (v.ok) begin
      if (cnt == 15 && (lead2 == 34 || lead2 == 37)) begin
        v.kind = luhn_pkg::KIND_AMEX;
      end else if (cnt == 16 && lead2 > 50 && lead2 < 56) begin
        v.kind = luhn_pkg::KIND_MC;
      end else if ((cnt == 13 || cnt == 16) && lead1 == 4) begin
        v.kind = luhn_pkg::KIND_VISA;
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (report_lines < 100) begin
      $display("%0t ns: mismatch: %s", $time, what);
      report_lines++;
    end
  endtask

  always @(posedge clk) begin : watch
    card_verdict_t want;
    if (rst_n) begin
      // results first, so a result can never match a request taken at the same edge
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request waiting", out_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[1:0] !== want.kind) begin
            report_mismatch($sformatf("card %0d: card_kind %0d, expected %0d",
                                      want.card, out_tdata[1:0], want.kind));
          end
          if (out_tdata[2] !== want.ok) begin
            report_mismatch($sformatf("card %0d: checksum_ok %0b, expected %0b",
                                      want.card, out_tdata[2], want.ok));
          end
          if (out_tdata[7:3] !== want.total) begin
            report_mismatch($sformatf("card %0d: digit_total %0d, expected %0d",
                                      want.card, out_tdata[7:3], want.total));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        verdict_q.push_back(classify_card(in_tdata[luhn_pkg::CARD_W-1:0]));
      end
    end
    pending_cnt = verdict_q.size();
  end

endmodule

[tb/sv/tb_luhn_card_number_classifier.sv]
// Testbench top for the Luhn card number classifier: clock, reset, request and result traffic.
module tb_luhn_card_number_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT    = 28;
  localparam int RAND_CARDS  = 1850;
  localparam int CALM_FROM   = 60000;
  localparam int CALM_TO     = 90000;
  localparam int HOLD_FROM   = 20000;
  localparam int HOLD_LEN    = 1500;
  localparam int TAIL_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [62:0] card_value, [63] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [1:0] card_kind, [2] checksum_ok, [7:3] digit_total
  int          cycle_cnt = 0;
  int          mismatch_cnt;
  int          pending_cnt;

  logic [luhn_pkg::CARD_W-1:0] directed_q[$];

  luhn_card_number_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  luhn_card_number_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // card number of ndig digits, optional leading prefix, optionally with a correct check digit
  function automatic logic [luhn_pkg::CARD_W-1:0] build_card(input int unsigned ndig,
                                                             input int unsigned prefix,
                                                             input int unsigned plen,
                                                             input bit          fix);
    int unsigned d[19];
    int unsigned sum;
    int unsigned x;
    int unsigned p;
    logic [63:0] v;
    for (p = 0; p < ndig; p++) begin
      d[p] = $urandom_range(0, 9);
    end
    if (plen == 2) begin
      d[ndig-1] = prefix / 10;
      d[ndig-2] = prefix % 10;
    end else if (plen == 1) begin
      d[ndig-1] = prefix;
    end else if (ndig > 1) begin
      d[ndig-1] = $urandom_range(1, 9);
    end
    // keep 19-digit numbers inside 63 bits
    if (ndig == 19 && d[18] == 9) begin
      d[18] = $urandom_range(1, 8);
    end
    if (fix) begin
      d[0] = 0;
      sum  = 0;
      for (p = 0; p < ndig; p++) begin
        x = d[p];
        if ((p % 2) == 1) begin
          x = 2 * x;
          if (x > 9) begin
            x = x - 9;
          end
        end
        sum += x;
      end
      d[0] = (10 - sum % 10) % 10;
    end
    v = 64'd0;
    for (p = ndig; p > 0; p--) begin
      v = v * 64'd10 + 64'(d[p-1]);
    end
    return v[luhn_pkg::CARD_W-1:0];
  endfunction

  function automatic logic [luhn_pkg::CARD_W-1:0] spoil_check_digit(
    input logic [luhn_pkg::CARD_W-1:0] card
  );
    return (card % 10 == 9) ? card - 1 : card + 1;
  endfunction

  function automatic logic [luhn_pkg::CARD_W-1:0] pick_card();
    int unsigned                 r;
    int unsigned                 kind_pick;
    int unsigned                 prefix;
    logic [63:0]                 raw;
    logic [luhn_pkg::CARD_W-1:0] c;
    r         = $urandom_range(0, 99);
    kind_pick = $urandom_range(0, 3);
    case (kind_pick)
      0: begin
        c = build_card(15, $urandom_range(0, 1) ? 34 : 37, 2, 1'b1);
      end
      1: begin
        prefix = $urandom_range(51, 55);
        if ($urandom_range(0, 9) == 0) begin
          prefix = $urandom_range(0, 1) ? 50 : 56;
        end
        c = build_card(16, prefix, 2, 1'b1);
      end
      2: begin
        c = build_card($urandom_range(0, 1) ? 13 : 16, 4, 1, 1'b1);
      end
      default: begin
        c = build_card($urandom_range(2, 19), $urandom_range(10, 99), 2, 1'b1);
      end
    endcase
    raw = {$urandom, $urandom};
    if (r < 60) begin
      return c;
    end else if (r < 75) begin
      return spoil_check_digit(c);
    end else if (r < 90) begin
      return raw[luhn_pkg::CARD_W-1:0];
    end
    // any digit count, down to one digit
    return raw[luhn_pkg::CARD_W-1:0] >> $urandom_range(0, luhn_pkg::CARD_W - 1);
  endfunction

  task automatic send_card(input logic [luhn_pkg::CARD_W-1:0] card);
    int gap;
    gap = 0;
    if ((cycle_cnt < CALM_FROM || cycle_cnt >= CALM_TO) && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 120);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, card};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin : result_sink
    int since_reset;
    out_tready  = 1'b0;
    since_reset = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        since_reset++;
      end
      if (!rst_n || (since_reset >= HOLD_FROM && since_reset < HOLD_FROM + HOLD_LEN)) begin
        out_tready <= 1'b0;
      end else if (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_luhn_card_number_classifier failed");
    $finish;
  end

  initial begin : request_source
    logic [63:0] big;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 64'd0;
    big       = 64'd1_000_000_000_000_000_000;

    // zero, one digit, powers of ten, full width
    directed_q.push_back('0);
    directed_q.push_back(luhn_pkg::CARD_W'(7));
    directed_q.push_back(luhn_pkg::CARD_W'(4));
    directed_q.push_back(luhn_pkg::CARD_W'(59));
    directed_q.push_back(luhn_pkg::CARD_W'(10));
    directed_q.push_back(big[luhn_pkg::CARD_W-1:0]);
    directed_q.push_back({luhn_pkg::CARD_W{1'b1}});
    directed_q.push_back({1'b1, {(luhn_pkg::CARD_W-1){1'b0}}});
    // prefix and length boundaries of each card kind
    directed_q.push_back(build_card(15, 34, 2, 1'b1));
    directed_q.push_back(build_card(15, 37, 2, 1'b1));
    directed_q.push_back(build_card(15, 35, 2, 1'b1));
    directed_q.push_back(build_card(16, 34, 2, 1'b1));
    directed_q.push_back(build_card(16, 51, 2, 1'b1));
    directed_q.push_back(build_card(16, 55, 2, 1'b1));
    directed_q.push_back(build_card(16, 50, 2, 1'b1));
    directed_q.push_back(build_card(16, 56, 2, 1'b1));
    directed_q.push_back(build_card(13, 4, 1, 1'b1));
    directed_q.push_back(build_card(16, 4, 1, 1'b1));
    directed_q.push_back(build_card(15, 4, 1, 1'b1));
    directed_q.push_back(build_card(12, 4, 1, 1'b1));
    directed_q.push_back(build_card(19, 0, 0, 1'b1));
    // failing checksum on otherwise matching cards
    directed_q.push_back(spoil_check_digit(build_card(16, 4, 1, 1'b1)));
    directed_q.push_back(spoil_check_digit(build_card(15, 37, 2, 1'b1)));
    directed_q.push_back(spoil_check_digit(build_card(16, 53, 2, 1'b1)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) begin
      send_card(directed_q[i]);
    end
    repeat (RAND_CARDS) begin
      send_card(pick_card());
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("tb_luhn_card_number_classifier passed");
    end else begin
      $display("tb_luhn_card_number_classifier failed");
    end
    $finish;
  end

endmodule

[luhn_card_number_classifier.f]
rtl/luhn_pkg.sv
rtl/luhn_cell.sv
rtl/luhn_acc.sv
rtl/luhn_card_number_classifier.sv
tb/sv/luhn_card_number_checker.sv
tb/sv/tb_luhn_card_number_classifier.sv
